@@ rtl/core/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication: antecedent in parentheses, consequent may start with a delay
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) else $error(msg);

// implication checked on the next clock edge
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/scp_pkg.sv @@
`default_nettype none

package scp_pkg;

  // fixed point format of all coordinates
  localparam int FRAC_BITS = 16;
  // bits of a normal magnitude, up to and including one
  localparam int QW = FRAC_BITS + 1;
  // restoring square root steps for a 64-bit radicand
  localparam int SQRT_STEPS = 32;
  // width of the shifted numerator in the normal divider
  localparam int DW = 32 + FRAC_BITS;
  // stage counts of the pipeline parts
  localparam int FRONT_STAGES = 4;
  localparam int BACK_STAGES = 3;
  localparam int LATENCY = FRONT_STAGES + SQRT_STEPS + QW + BACK_STAGES;

  localparam logic [QW-1:0] NORM_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic {
    KIND_SPHERE = 1'b0,
    KIND_BOX    = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef logic [2:0][31:0] vec_t;
  typedef logic [2:0][QW-1:0] nvec_t;

  // per-request data that rides along the pipeline
  typedef struct packed {
    kind_t       kind;
    logic        hit;
    logic        zero;
    vec_t        a;
    vec_t        b;
    vec_t        c;
    vec_t        mag;
    logic [2:0]  neg;
    logic [2:0]  l_pos;
    logic [30:0] ra;
    logic [30:0] rb;
    logic [31:0] r_sum;
    axis_t       axis;
    logic [30:0] gmin;
  } side_t;

  // saturate a wide signed sum to 32 bits
  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -34'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/scp_front.sv @@
`default_nettype none

module scp_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              kind,
  input  wire scp_pkg::vec_t     a,
  input  wire scp_pkg::vec_t     b,
  input  wire logic [30:0]       radius_a,
  input  wire logic [30:0]       radius_b,
  input  wire logic [2:0][30:0]  half,
  output logic                   out_valid,
  output logic [63:0]            d2,
  output scp_pkg::side_t         side
);

  logic                  v1, v2, v3;
  scp_pkg::side_t        side1, side2, side3;
  scp_pkg::side_t        side1_next, side2_next, side4_next;
  logic signed [32:0]    diff1 [3];
  logic [2:0][30:0]      h1, h2;
  logic [31:0]           magl2 [3];
  logic [63:0]           sq3 [3];
  logic [63:0]           lim3;
  logic signed [33:0]    g3 [3];
  logic [65:0]           sum4;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  // stage 1: difference of centers
  always_comb begin
    side1_next = '0;
    side1_next.kind = scp_pkg::kind_t'(kind);
    side1_next.a = a;
    side1_next.b = b;
    side1_next.ra = radius_a;
    side1_next.rb = radius_b;
  end

  always_ff @(posedge clk) begin
    side1 <= side1_next;
    h1 <= half;
    for (int i = 0; i < 3; i++) begin
      if (kind == scp_pkg::KIND_BOX) begin
        diff1[i] <= $signed({a[i][31], a[i]}) - $signed({b[i][31], b[i]});
      end else begin
        diff1[i] <= $signed({b[i][31], b[i]}) - $signed({a[i][31], a[i]});
      end
    end
  end

  // stage 2: clamp to the box, separation vector magnitudes
  always_comb begin
    logic signed [32:0] hs;
    logic signed [32:0] cl;
    logic signed [32:0] dd;
    logic signed [32:0] ad;
    logic signed [32:0] al;
    side2_next = side1;
    for (int i = 0; i < 3; i++) begin
      hs = $signed({2'b00, h1[i]});
      if (side1.kind == scp_pkg::KIND_BOX) begin
        if (diff1[i] > hs) begin
          cl = hs;
        end else if (diff1[i] < -hs) begin
          cl = -hs;
        end else begin
          cl = diff1[i];
        end
      end else begin
        cl = '0;
      end
      dd = diff1[i] - cl;
      ad = dd[32] ? -dd : dd;
      al = diff1[i][32] ? -diff1[i] : diff1[i];
      side2_next.c[i] = cl[31:0];
      side2_next.mag[i] = ad[31:0];
      side2_next.neg[i] = dd[32];
      side2_next.l_pos[i] = !diff1[i][32] && (diff1[i] != 33'sd0);
      magl2[i] = al[31:0];
    end
    if (side1.kind == scp_pkg::KIND_BOX) begin
      side2_next.r_sum = {1'b0, side1.ra};
    end else begin
      side2_next.r_sum = {1'b0, side1.ra} + {1'b0, side1.rb};
    end
  end

  logic [31:0] magl2_q [3];

  always_ff @(posedge clk) begin
    side2 <= side2_next;
    h2 <= h1;
    for (int i = 0; i < 3; i++) begin
      magl2_q[i] <= magl2[i];
    end
  end

  // stage 3: squares and inside gaps
  always_ff @(posedge clk) begin
    side3 <= side2;
    lim3 <= side2.r_sum * side2.r_sum;
    for (int i = 0; i < 3; i++) begin
      sq3[i] <= side2.mag[i] * side2.mag[i];
      g3[i] <= $signed({3'b000, h2[i]}) - $signed({2'b00, magl2_q[i]});
    end
  end

  // stage 4: squared distance, hit test, nearest face
  always_comb begin
    logic signed [33:0] gm;
    sum4 = {2'b00, sq3[0]} + {2'b00, sq3[1]} + {2'b00, sq3[2]};
    side4_next = side3;
    side4_next.hit = (sum4 <= {2'b00, lim3});
    side4_next.zero = (sum4 == 66'd0);
    if (g3[0] < g3[1] && g3[0] < g3[2]) begin
      side4_next.axis = scp_pkg::AXIS_X;
    end else if (g3[1] < g3[2]) begin
      side4_next.axis = scp_pkg::AXIS_Y;
    end else begin
      side4_next.axis = scp_pkg::AXIS_Z;
    end
    gm = g3[0];
    if (g3[1] < gm) begin
      gm = g3[1];
    end
    if (g3[2] < gm) begin
      gm = g3[2];
    end
    side4_next.gmin = gm[30:0];
  end

  always_ff @(posedge clk) begin
    side <= side4_next;
    d2 <= sum4[63:0];
  end

endmodule

`default_nettype wire

@@ rtl/core/scp_sqrt.sv @@
`default_nettype none

module scp_sqrt (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [63:0]     radicand,
  input  wire scp_pkg::side_t  in_side,
  output logic                 out_valid,
  output logic [31:0]          root,
  output scp_pkg::side_t       out_side
);

  localparam int N = scp_pkg::SQRT_STEPS;

  logic           v_s    [N+1];
  logic [63:0]    x_s    [N+1];
  logic [63:0]    res_s  [N+1];
  scp_pkg::side_t side_s [N+1];

  assign v_s[0] = in_valid;
  assign x_s[0] = radicand;
  assign res_s[0] = '0;
  assign side_s[0] = in_side;

  // one digit of the root per stage
  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [64:0] trial;

    assign trial = {1'b0, res_s[k]} + {1'b0, BIT};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k+1] <= 1'b0;
      end else begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk) begin
      side_s[k+1] <= side_s[k];
      if ({1'b0, x_s[k]} >= trial) begin
        x_s[k+1] <= x_s[k] - trial[63:0];
        res_s[k+1] <= (res_s[k] >> 1) + BIT;
      end else begin
        x_s[k+1] <= x_s[k];
        res_s[k+1] <= res_s[k] >> 1;
      end
    end
  end

  assign out_valid = v_s[N];
  assign root = res_s[N][31:0];
  assign out_side = side_s[N];

endmodule

`default_nettype wire

@@ rtl/core/scp_div.sv @@
`default_nettype none

module scp_div (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [31:0]     dist_in,
  input  wire scp_pkg::side_t  in_side,
  output logic                 out_valid,
  output logic [31:0]          dist_out,
  output scp_pkg::nvec_t       quot,
  output scp_pkg::side_t       out_side
);

  localparam int N  = scp_pkg::QW;
  localparam int DW = scp_pkg::DW;
  localparam int FB = scp_pkg::FRAC_BITS;

  logic                 v_s    [N+1];
  logic [31:0]          dv_s   [N+1];
  logic [2:0][DW-1:0]   rem_s  [N+1];
  scp_pkg::nvec_t       quo_s  [N+1];
  scp_pkg::side_t       side_s [N+1];

  // numerator is the magnitude shifted up by the fraction bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_s[0][i] = {in_side.mag[i], {FB{1'b0}}};
    end
  end

  assign v_s[0] = in_valid;
  assign dv_s[0] = dist_in;
  assign quo_s[0] = '0;
  assign side_s[0] = in_side;

  // one quotient bit per stage, three lanes share the divisor
  for (genvar j = 0; j < N; j++) begin : g_step
    localparam int SH = FB - j;
    logic [DW-1:0] dsh;

    assign dsh = DW'(dv_s[j]) << SH;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[j+1] <= 1'b0;
      end else begin
        v_s[j+1] <= v_s[j];
      end
    end

    always_ff @(posedge clk) begin
      dv_s[j+1] <= dv_s[j];
      side_s[j+1] <= side_s[j];
      for (int i = 0; i < 3; i++) begin
        if (rem_s[j][i] >= dsh) begin
          rem_s[j+1][i] <= rem_s[j][i] - dsh;
          quo_s[j+1][i] <= {quo_s[j][i][N-2:0], 1'b1};
        end else begin
          rem_s[j+1][i] <= rem_s[j][i];
          quo_s[j+1][i] <= {quo_s[j][i][N-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v_s[N];
  assign dist_out = dv_s[N];
  assign quot = quo_s[N];
  assign out_side = side_s[N];

endmodule

`default_nettype wire

@@ rtl/core/scp_back.sv @@
`default_nettype none

module scp_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [31:0]     dist_len,
  input  wire scp_pkg::nvec_t  quot,
  input  wire scp_pkg::side_t  in_side,
  output logic                 done,
  output logic                 hit,
  output scp_pkg::vec_t        normal,
  output logic [31:0]          depth,
  output scp_pkg::vec_t        point_a,
  output scp_pkg::vec_t        point_b
);

  localparam int FB = scp_pkg::FRAC_BITS;
  localparam int QW = scp_pkg::QW;

  logic                 v1, v2;
  scp_pkg::side_t       side1, side2;
  scp_pkg::nvec_t       nmag1, nmag2;
  logic [2:0]           nneg1, nneg2;
  logic [31:0]          depth1, depth2;
  scp_pkg::nvec_t       nmag_next;
  logic [2:0]           nneg_next;
  logic [31:0]          depth_next;
  logic [QW+30:0]       prod_a [3];
  logic [QW+30:0]       prod_b [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      done <= v2;
    end
  end

  // stage 1: pick the normal and the depth
  always_comb begin
    logic signed [33:0] dw;
    nmag_next = '0;
    nneg_next = '0;
    if (!in_side.zero) begin
      nmag_next = quot;
      nneg_next = in_side.neg;
    end else if (in_side.kind == scp_pkg::KIND_SPHERE) begin
      nmag_next[1] = scp_pkg::NORM_ONE;
    end else begin
      nmag_next[in_side.axis] = scp_pkg::NORM_ONE;
      nneg_next[in_side.axis] = !in_side.l_pos[in_side.axis];
    end
    if (in_side.kind == scp_pkg::KIND_SPHERE) begin
      dw = $signed({2'b00, in_side.r_sum}) - $signed({2'b00, dist_len});
    end else if (!in_side.zero) begin
      dw = $signed({3'b000, in_side.ra}) - $signed({2'b00, dist_len});
    end else begin
      dw = $signed({3'b000, in_side.ra}) + $signed({3'b000, in_side.gmin});
    end
    if (dw[33]) begin
      depth_next = '0;
    end else begin
      depth_next = scp_pkg::sat32(dw);
    end
  end

  always_ff @(posedge clk) begin
    side1 <= in_side;
    nmag1 <= nmag_next;
    nneg1 <= nneg_next;
    depth1 <= depth_next;
  end

  // stage 2: normal times radius
  always_ff @(posedge clk) begin
    side2 <= side1;
    nmag2 <= nmag1;
    nneg2 <= nneg1;
    depth2 <= depth1;
    for (int i = 0; i < 3; i++) begin
      prod_a[i] <= nmag1[i] * side1.ra;
      prod_b[i] <= nmag1[i] * side1.rb;
    end
  end

  // stage 3: contact points, zeroed on a miss
  always_ff @(posedge clk) begin
    logic signed [33:0] ta;
    logic signed [33:0] tb;
    logic signed [33:0] ax;
    logic signed [33:0] bx;
    logic signed [33:0] cx;
    logic [31:0]        nm;
    hit <= side2.hit;
    depth <= side2.hit ? depth2 : '0;
    for (int i = 0; i < 3; i++) begin
      ta = $signed({3'b000, prod_a[i][FB +: 31]});
      tb = $signed({3'b000, prod_b[i][FB +: 31]});
      ax = $signed({{2{side2.a[i][31]}}, side2.a[i]});
      bx = $signed({{2{side2.b[i][31]}}, side2.b[i]});
      cx = $signed({{2{side2.c[i][31]}}, side2.c[i]});
      nm = 32'(nmag2[i]);
      if (!side2.hit) begin
        normal[i] <= '0;
        point_a[i] <= '0;
        point_b[i] <= '0;
      end else begin
        normal[i] <= nneg2[i] ? -nm : nm;
        if (nneg2[i] ^ (side2.kind == scp_pkg::KIND_BOX)) begin
          point_a[i] <= scp_pkg::sat32(ax - ta);
        end else begin
          point_a[i] <= scp_pkg::sat32(ax + ta);
        end
        if (side2.kind == scp_pkg::KIND_BOX) begin
          point_b[i] <= scp_pkg::sat32(cx + bx);
        end else if (nneg2[i]) begin
          point_b[i] <= scp_pkg::sat32(bx + tb);
        end else begin
          point_b[i] <= scp_pkg::sat32(bx - tb);
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sphere_primitive_contact_top.sv @@
`default_nettype none

// channel   | handshake          | fields
// ----------+--------------------+------------------------------------------
// request   | start, busy        | kind, a_*, b_*, radius_a/b, half_*
// result    | done (one cycle)   | hit, normal_*, depth, point_a_*, point_b_*
//
// a request is taken at every edge with start high; busy never rises
// each request passes through 4 setup stages, 32 root
// stages (one root digit each), 17 divide stages (one normal bit each), 3 output stages
// one request per cycle is sustained, requests overlap freely
// reset clears only the valid bits of the pipeline; no result can be held off

module sphere_primitive_contact_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire logic         kind,
  input  wire logic [31:0]  a_x,
  input  wire logic [31:0]  a_y,
  input  wire logic [31:0]  a_z,
  input  wire logic [31:0]  b_x,
  input  wire logic [31:0]  b_y,
  input  wire logic [31:0]  b_z,
  input  wire logic [30:0]  radius_a,
  input  wire logic [30:0]  radius_b,
  input  wire logic [30:0]  half_x,
  input  wire logic [30:0]  half_y,
  input  wire logic [30:0]  half_z,
  output logic              done,
  output logic              hit,
  output logic [31:0]       normal_x,
  output logic [31:0]       normal_y,
  output logic [31:0]       normal_z,
  output logic [31:0]       depth,
  output logic [31:0]       point_a_x,
  output logic [31:0]       point_a_y,
  output logic [31:0]       point_a_z,
  output logic [31:0]       point_b_x,
  output logic [31:0]       point_b_y,
  output logic [31:0]       point_b_z
);

  scp_pkg::vec_t    a_v, b_v;
  logic [2:0][30:0] half_v;
  logic             f_valid, s_valid, d_valid;
  logic [63:0]      d2;
  logic [31:0]      root, dist_len;
  scp_pkg::side_t   f_side, s_side, d_side;
  scp_pkg::nvec_t   quot;
  scp_pkg::vec_t    normal_v, pa_v, pb_v;

  // the pipeline never stalls
  assign busy = 1'b0;

  assign a_v = {a_z, a_y, a_x};
  assign b_v = {b_z, b_y, b_x};
  assign half_v = {half_z, half_y, half_x};

  scp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .kind      (kind),
    .a         (a_v),
    .b         (b_v),
    .radius_a  (radius_a),
    .radius_b  (radius_b),
    .half      (half_v),
    .out_valid (f_valid),
    .d2        (d2),
    .side      (f_side)
  );

  scp_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .radicand  (d2),
    .in_side   (f_side),
    .out_valid (s_valid),
    .root      (root),
    .out_side  (s_side)
  );

  scp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .dist_in   (root),
    .in_side   (s_side),
    .out_valid (d_valid),
    .dist_out  (dist_len),
    .quot      (quot),
    .out_side  (d_side)
  );

  scp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d_valid),
    .dist_len (dist_len),
    .quot     (quot),
    .in_side  (d_side),
    .done     (done),
    .hit      (hit),
    .normal   (normal_v),
    .depth    (depth),
    .point_a  (pa_v),
    .point_b  (pb_v)
  );

  assign normal_x = normal_v[0];
  assign normal_y = normal_v[1];
  assign normal_z = normal_v[2];
  assign point_a_x = pa_v[0];
  assign point_a_y = pa_v[1];
  assign point_a_z = pa_v[2];
  assign point_b_x = pb_v[0];
  assign point_b_y = pb_v[1];
  assign point_b_z = pb_v[2];

endmodule

`default_nettype wire

@@ rtl/core/scp_check.sv @@
`default_nettype none

`include "assert_macros.svh"

module scp_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic        hit,
  input wire logic [31:0] normal_x,
  input wire logic [31:0] normal_y,
  input wire logic [31:0] normal_z,
  input wire logic [31:0] depth,
  input wire logic [31:0] point_a_x,
  input wire logic [31:0] point_a_y,
  input wire logic [31:0] point_a_z,
  input wire logic [31:0] point_b_x,
  input wire logic [31:0] point_b_y,
  input wire logic [31:0] point_b_z
);

  // every request comes back after the fixed pipeline depth
  `ASSERT_IMPLY(a_latency, clk, rst, start && !busy, ##(scp_pkg::LATENCY) done, "result missing after request")

  // a miss reports an all-zero contact
  `ASSERT_IMPLY(a_miss_zero, clk, rst, done && !hit, normal_x == 32'd0 && normal_y == 32'd0 && normal_z == 32'd0 && depth == 32'd0 && point_a_x == 32'd0 && point_a_y == 32'd0 && point_a_z == 32'd0 && point_b_x == 32'd0 && point_b_y == 32'd0 && point_b_z == 32'd0, "miss with nonzero contact")

  // a hit carries a nonzero normal and a nonnegative depth
  `ASSERT_IMPLY(a_hit_normal, clk, rst, done && hit, !depth[31] && (normal_x != 32'd0 || normal_y != 32'd0 || normal_z != 32'd0), "hit with bad normal or depth")

  // reset flushes the pipeline
  `ASSERT_NEXT(a_reset_flush, clk, 1'b0, rst, !done, "result right after reset")

endmodule

bind sphere_primitive_contact_top scp_check u_scp_check (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .hit       (hit),
  .normal_x  (normal_x),
  .normal_y  (normal_y),
  .normal_z  (normal_z),
  .depth     (depth),
  .point_a_x (point_a_x),
  .point_a_y (point_a_y),
  .point_a_z (point_a_z),
  .point_b_x (point_b_x),
  .point_b_y (point_b_y),
  .point_b_z (point_b_z)
);

`default_nettype wire
